/* sv/lmrfs_pkg.sv */
// shared types, constants and codes for the led matrix row frame store
// no dependencies
package lmrfs_pkg;

	localparam int MAX_ROWS    = 16;
	localparam int MAX_COLUMNS = 32;
	localparam int ROW_BITS    = ((MAX_ROWS + MAX_COLUMNS + 7) / 8) * 8;
	localparam int SLOT_BYTES  = ROW_BITS / 8;

	localparam int ROW_IDX_W  = $clog2(MAX_ROWS);
	localparam int COL_IDX_W  = $clog2(MAX_COLUMNS);
	localparam int ROWS_W     = $clog2(MAX_ROWS + 1);
	localparam int COLS_W     = $clog2(MAX_COLUMNS + 1);
	localparam int POS_W      = $clog2(ROW_BITS);
	localparam int BCNT_W     = $clog2(SLOT_BYTES + 1);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	localparam logic [ROW_BITS-1:0] ROW_TOP = {1'b1, {(ROW_BITS-1){1'b0}}};

	typedef enum logic [2:0] {
		REQ_CLEAR      = 3'd0,
		REQ_SET_PIXEL  = 3'd1,
		REQ_ROW_SELECT = 3'd2,
		REQ_UNMARK     = 3'd3,
		REQ_TRANSMIT   = 3'd4,
		REQ_QUERY      = 3'd5
	} req_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS      = 2'd0,
		REG_COLUMNS   = 2'd1,
		REG_COL_LEVEL = 2'd2,
		REG_ROW_LEVEL = 2'd3
	} cfg_reg_t;

	// configuration as seen by the datapath, sizes already saturated
	typedef struct packed {
		logic [ROWS_W-1:0] rows_used;
		logic [COLS_W-1:0] cols_used;
		logic              col_level;
		logic              row_level;
	} cfg_t;

	// one job for the row merge unit
	typedef struct packed {
		logic [ROW_BITS-1:0] base;
		logic [POS_W-1:0]    start;
		logic [ROWS_W-1:0]   len;
		logic                flip_en;
		logic [POS_W-1:0]    flip_pos;
		logic                level;
	} upd_req_t;

endpackage

/* sv/lmrfs_cfg_regs.sv */
// configuration registers of the frame store, with saturation of the sizes
// depends on lmrfs_pkg
module lmrfs_cfg_regs
	import lmrfs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	logic [4:0] matrix_rows_q;
	logic [5:0] matrix_columns_q;
	logic       column_on_level_q;
	logic       row_on_level_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_rows_q     <= 5'd8;
			matrix_columns_q  <= 6'd8;
			column_on_level_q <= 1'b1;
			row_on_level_q    <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ROWS:      matrix_rows_q     <= cfg_data[4:0];
				REG_COLUMNS:   matrix_columns_q  <= cfg_data[5:0];
				REG_COL_LEVEL: column_on_level_q <= cfg_data[0];
				REG_ROW_LEVEL: row_on_level_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (matrix_rows_q == '0)
			cfg.rows_used = ROWS_W'(1);
		else if (matrix_rows_q > 5'(MAX_ROWS))
			cfg.rows_used = ROWS_W'(MAX_ROWS);
		else
			cfg.rows_used = ROWS_W'(matrix_rows_q);

		if (matrix_columns_q == '0)
			cfg.cols_used = COLS_W'(1);
		else if (matrix_columns_q > 6'(MAX_COLUMNS))
			cfg.cols_used = COLS_W'(MAX_COLUMNS);
		else
			cfg.cols_used = COLS_W'(matrix_columns_q);

		cfg.col_level = column_on_level_q;
		cfg.row_level = row_on_level_q;
	end

endmodule

/* sv/lmrfs_row_unit.sv */
// shared row merge unit: shifts a run mask and a one-hot into place and
// merges a level into a stored row; depends on lmrfs_pkg
module lmrfs_row_unit
	import lmrfs_pkg::*;
(
	input  upd_req_t            upd,
	output logic [ROW_BITS-1:0] row_new
);

	logic [ROW_BITS-1:0] mask;
	logic [ROW_BITS-1:0] flip;
	logic [ROW_BITS-1:0] level_v;

	// bit position 0 sits at the msb of the row vector
	always_comb begin
		mask    = (~({ROW_BITS{1'b1}} >> upd.len)) >> upd.start;
		flip    = upd.flip_en ? (ROW_TOP >> upd.flip_pos) : '0;
		level_v = {ROW_BITS{upd.level}} ^ flip;
		row_new = (upd.base & ~mask) | (mask & level_v);
	end

endmodule

/* sv/led_matrix_row_frame_store_core.sv */
// frame store for a shift-register led matrix: set pixel and row select write
// the row when accepted, clear walks all 16 row slots through the merge unit,
// transmit latches the row and then gives one byte per cycle while the output
// is not stalled (up to 6), and query answers from a registered mark.
// reset clears the frame and marks and loads 8 rows, 8 columns, active-high.
module led_matrix_row_frame_store_core
	import lmrfs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic [2:0]            req_type,
	input  logic [ROW_IDX_W-1:0]  row_index,
	input  logic [COL_IDX_W-1:0]  column_index,
	input  logic                  is_on,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output logic                  result_kind,
	output logic [7:0]            row_byte,
	output logic                  last_byte,
	output logic                  row_marked
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_EMIT
	} state_t;

	cfg_t                cfg;
	upd_req_t            upd;
	logic [ROW_BITS-1:0] row_new;

	state_t                state_q;
	logic [ROW_IDX_W-1:0]  clr_row_q;
	logic [ROW_BITS-1:0]   tx_row_q;
	logic [BCNT_W-1:0]     bytes_left_q;
	logic                  is_query_q;
	logic                  mark_q;
	logic                  rsp_valid_q;
	logic                  result_kind_q;
	logic [7:0]            row_byte_q;
	logic                  last_byte_q;
	logic                  row_marked_q;

	logic [ROW_BITS-1:0] row_bits_q [MAX_ROWS];
	logic [MAX_ROWS-1:0] row_marks_q;

	logic                 req_accept;
	logic                 row_ok;
	logic                 col_ok;
	logic                 clr_row_in;
	logic [POS_W-1:0]     own_pos;
	logic [POS_W-1:0]     sum_m1;
	logic [BCNT_W-1:0]    n_bytes;
	logic                 wr_en;
	logic [ROW_IDX_W-1:0] wr_row;
	logic                 out_free;

	lmrfs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lmrfs_row_unit u_row (
		.upd     (upd),
		.row_new (row_new)
	);

	assign req_stall  = (state_q != ST_IDLE);
	assign req_accept = req_valid && !req_stall;
	assign row_ok     = ROWS_W'(row_index) < cfg.rows_used;
	assign col_ok     = COLS_W'(column_index) < cfg.cols_used;
	assign clr_row_in = ROWS_W'(clr_row_q) < cfg.rows_used;
	assign out_free   = !rsp_valid_q || !rsp_stall;

	// own select bit: the last row comes first after the columns
	assign own_pos = POS_W'(cfg.cols_used) + POS_W'(cfg.rows_used)
		- POS_W'(1) - POS_W'(row_index);
	assign sum_m1  = POS_W'(cfg.cols_used) + POS_W'(cfg.rows_used) - POS_W'(1);
	assign n_bytes = BCNT_W'(1) + BCNT_W'(sum_m1 >> 3);

	always_comb begin
		upd.base     = row_bits_q[row_index];
		upd.start    = POS_W'(cfg.cols_used);
		upd.len      = cfg.rows_used;
		upd.flip_en  = is_on;
		upd.flip_pos = own_pos;
		upd.level    = !cfg.row_level;
		if (state_q == ST_CLEAR) begin
			upd.base    = {ROW_BITS{!cfg.col_level}};
			upd.len     = clr_row_in ? cfg.rows_used : '0;
			upd.flip_en = 1'b0;
		end else if (req_type == REQ_SET_PIXEL) begin
			upd.start   = POS_W'(column_index);
			upd.len     = ROWS_W'(1);
			upd.flip_en = 1'b0;
			upd.level   = (is_on == cfg.col_level);
		end
	end

	assign wr_row = (state_q == ST_CLEAR) ? clr_row_q : row_index;
	assign wr_en  = (state_q == ST_CLEAR)
		|| (req_accept && row_ok
			&& ((req_type == REQ_SET_PIXEL && col_ok) || req_type == REQ_ROW_SELECT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < MAX_ROWS; r++)
				row_bits_q[r] <= '0;
		end else if (wr_en) begin
			row_bits_q[wr_row] <= row_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_marks_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			if (clr_row_in)
				row_marks_q[clr_row_q] <= 1'b1;
		end else if (req_accept && row_ok) begin
			if (req_type == REQ_ROW_SELECT)
				row_marks_q[row_index] <= 1'b1;
			else if (req_type == REQ_UNMARK)
				row_marks_q[row_index] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			clr_row_q     <= '0;
			tx_row_q      <= '0;
			bytes_left_q  <= '0;
			is_query_q    <= 1'b0;
			mark_q        <= 1'b0;
			rsp_valid_q   <= 1'b0;
			result_kind_q <= 1'b0;
			row_byte_q    <= '0;
			last_byte_q   <= 1'b0;
			row_marked_q  <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free)
				rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req_accept) begin
						unique case (req_code_t'(req_type))
							REQ_CLEAR: begin
								clr_row_q <= '0;
								state_q   <= ST_CLEAR;
							end
							REQ_TRANSMIT: begin
								if (row_ok) begin
									tx_row_q     <= row_bits_q[row_index];
									bytes_left_q <= n_bytes;
									is_query_q   <= 1'b0;
									state_q      <= ST_EMIT;
								end
							end
							REQ_QUERY: begin
								is_query_q <= 1'b1;
								mark_q     <= row_ok && row_marks_q[row_index];
								state_q    <= ST_EMIT;
							end
							default: ;
						endcase
					end
				end
				ST_CLEAR: begin
					clr_row_q <= clr_row_q + ROW_IDX_W'(1);
					if (clr_row_q == ROW_IDX_W'(MAX_ROWS - 1))
						state_q <= ST_IDLE;
				end
				ST_EMIT: begin
					if (out_free) begin
						if (is_query_q) begin
							result_kind_q <= 1'b1;
							row_byte_q    <= '0;
							last_byte_q   <= 1'b0;
							row_marked_q  <= mark_q;
							state_q       <= ST_IDLE;
						end else begin
							result_kind_q <= 1'b0;
							row_byte_q    <= tx_row_q[ROW_BITS-1 -: 8];
							last_byte_q   <= (bytes_left_q == BCNT_W'(1));
							row_marked_q  <= 1'b0;
							tx_row_q      <= tx_row_q << 8;
							bytes_left_q  <= bytes_left_q - BCNT_W'(1);
							if (bytes_left_q == BCNT_W'(1))
								state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign result_kind = result_kind_q;
	assign row_byte    = row_byte_q;
	assign last_byte   = last_byte_q;
	assign row_marked  = row_marked_q;

	// a mark answer never carries row data or a last flag
	a_query_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && result_kind |-> !last_byte && row_byte == '0)
		else $error("mark answer carries byte data");

	// a transmit in flight always has between one and a full slot of bytes left
	a_bytes_left: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && !is_query_q
			|-> bytes_left_q != '0 && bytes_left_q <= BCNT_W'(SLOT_BYTES))
		else $error("transmit byte count out of range");

	// the clear walk starts at row zero only when it has just been entered
	a_clear_start: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR && $past(state_q) == ST_CLEAR |-> clr_row_q != '0)
		else $error("clear walk wrapped without leaving");

endmodule

/* sim/led_matrix_row_frame_store_core_test.sv */
// self-checking testbench for led_matrix_row_frame_store_core: a directed table,
// then random requests over several matrix sizes and levels, checked against a frame predictor
// depends on lmrfs_pkg and the core
`timescale 1ns / 1ps

module led_matrix_row_frame_store_core_test;
	import lmrfs_pkg::*;

	localparam int SETTLE_CYCLES = 24;
	localparam int HOLD_CYCLES   = 150;
	localparam int PHASE_ITEMS   = 11;

	localparam logic RSP_BYTE = 1'b0;
	localparam logic RSP_MARK = 1'b1;

	localparam logic [2:0] REQ_SPARE_6 = 3'd6;
	localparam logic [2:0] REQ_SPARE_7 = 3'd7;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic       last;
		logic       mark;
	} answer_t;

	typedef struct packed {
		logic [2:0]           op;
		logic [ROW_IDX_W-1:0] row;
		logic [COL_IDX_W-1:0] col;
		logic                 on;
		logic                 typed;
		logic                 mark;
	} step_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  req_valid;
	logic                  req_stall;
	logic [2:0]            req_type;
	logic [ROW_IDX_W-1:0]  row_index;
	logic [COL_IDX_W-1:0]  column_index;
	logic                  is_on;
	logic                  rsp_valid;
	logic                  rsp_stall;
	logic                  result_kind;
	logic [7:0]            row_byte;
	logic                  last_byte;
	logic                  row_marked;

	// predicted frame and configuration
	logic [ROW_BITS-1:0] frame_bits [MAX_ROWS];
	logic [MAX_ROWS-1:0] mark_flags;
	logic [4:0]          cfg_rows;
	logic [5:0]          cfg_cols;
	logic                cfg_col_level;
	logic                cfg_row_level;

	answer_t awaited_answers [$];
	int      mismatches = 0;
	bit      sender_idles = 1'b1;
	bit      receiver_idles = 1'b1;
	int      long_hold = 0;

	// only query rows carry a typed answer
	step_t directed [25] = '{
		'{REQ_QUERY,      4'd0,  5'd0,  1'b0, 1'b1, 1'b0},
		'{REQ_TRANSMIT,   4'd0,  5'd0,  1'b0, 1'b0, 1'b0},
		'{REQ_TRANSMIT,   4'd15, 5'd31, 1'b1, 1'b0, 1'b0},
		'{REQ_QUERY,      4'd15, 5'd0,  1'b0, 1'b1, 1'b0},
		'{REQ_CLEAR,      4'd0,  5'd0,  1'b0, 1'b0, 1'b0},
		'{REQ_QUERY,      4'd7,  5'd0,  1'b0, 1'b1, 1'b1},
		'{REQ_TRANSMIT,   4'd7,  5'd0,  1'b0, 1'b0, 1'b0},
		'{REQ_SET_PIXEL,  4'd0,  5'd0,  1'b1, 1'b0, 1'b0},
		'{REQ_SET_PIXEL,  4'd0,  5'd7,  1'b1, 1'b0, 1'b0},
		'{REQ_SET_PIXEL,  4'd0,  5'd8,  1'b1, 1'b0, 1'b0},
		'{REQ_SET_PIXEL,  4'd7,  5'd31, 1'b1, 1'b0, 1'b0},
		'{REQ_ROW_SELECT, 4'd0,  5'd0,  1'b1, 1'b0, 1'b0},
		'{REQ_TRANSMIT,   4'd0,  5'd0,  1'b0, 1'b0, 1'b0},
		'{REQ_ROW_SELECT, 4'd7,  5'd0,  1'b0, 1'b0, 1'b0},
		'{REQ_UNMARK,     4'd0,  5'd0,  1'b0, 1'b0, 1'b0},
		'{REQ_QUERY,      4'd0,  5'd0,  1'b0, 1'b1, 1'b0},
		'{REQ_QUERY,      4'd7,  5'd0,  1'b0, 1'b1, 1'b1},
		'{REQ_SPARE_6,    4'd0,  5'd0,  1'b1, 1'b0, 1'b0},
		'{REQ_SPARE_7,    4'd15, 5'd31, 1'b1, 1'b0, 1'b0},
		'{REQ_SET_PIXEL,  4'd3,  5'd5,  1'b1, 1'b0, 1'b0},
		'{REQ_SET_PIXEL,  4'd3,  5'd5,  1'b0, 1'b0, 1'b0},
		'{REQ_TRANSMIT,   4'd3,  5'd0,  1'b0, 1'b0, 1'b0},
		'{REQ_UNMARK,     4'd15, 5'd0,  1'b0, 1'b0, 1'b0},
		'{REQ_ROW_SELECT, 4'd15, 5'd0,  1'b1, 1'b0, 1'b0},
		'{REQ_TRANSMIT,   4'd7,  5'd31, 1'b1, 1'b0, 1'b0}
	};

	// sizes include out-of-range codes that saturate
	logic [4:0] phase_rows [6] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd8};
	logic [5:0] phase_cols [6] = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd20, 6'd8};
	logic       phase_cl   [6] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
	logic       phase_rl   [6] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

	led_matrix_row_frame_store_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req_type     (req_type),
		.row_index    (row_index),
		.column_index (column_index),
		.is_on        (is_on),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.result_kind  (result_kind),
		.row_byte     (row_byte),
		.last_byte    (last_byte),
		.row_marked   (row_marked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int rows_in_use();
		if (cfg_rows < 1) return 1;
		if (cfg_rows > MAX_ROWS) return MAX_ROWS;
		return int'(cfg_rows);
	endfunction

	function automatic int cols_in_use();
		if (cfg_cols < 1) return 1;
		if (cfg_cols > MAX_COLUMNS) return MAX_COLUMNS;
		return int'(cfg_cols);
	endfunction

	// bit position 0 is the msb of byte 0
	task automatic put_level(int r, int pos, logic level);
		if (pos < ROW_BITS) frame_bits[r][ROW_BITS-1-pos] = level;
	endtask

	task automatic select_row(int r, logic on);
		int rows;
		int cols;
		int own;
		rows = rows_in_use();
		cols = cols_in_use();
		own = rows - r - 1;
		for (int i = 0; i < rows; i++)
			put_level(r, cols + i, (on && (i == own)) ? cfg_row_level : ~cfg_row_level);
		mark_flags[r] = 1'b1;
	endtask

	task automatic apply_frame_request(logic [2:0] op, int r, int c, logic on);
		int   rows;
		int   nbytes;
		logic row_ok;
		rows = rows_in_use();
		row_ok = (r < rows);
		case (op)
			REQ_CLEAR: begin
				for (int s = 0; s < MAX_ROWS; s++)
					frame_bits[s] = {ROW_BITS{~cfg_col_level}};
				for (int s = 0; s < rows; s++) select_row(s, 1'b0);
			end
			REQ_SET_PIXEL: begin
				if (row_ok && c < cols_in_use()) put_level(r, c, on == cfg_col_level);
			end
			REQ_ROW_SELECT: begin
				if (row_ok) select_row(r, on);
			end
			REQ_UNMARK: begin
				if (row_ok) mark_flags[r] = 1'b0;
			end
			REQ_TRANSMIT: begin
				if (row_ok) begin
					nbytes = 1 + (rows + cols_in_use() - 1) / 8;
					if (nbytes > SLOT_BYTES) nbytes = SLOT_BYTES;
					for (int k = 0; k < nbytes; k++)
						awaited_answers.push_back('{RSP_BYTE,
							frame_bits[r][ROW_BITS-1-8*k -: 8],
							k == nbytes - 1, 1'b0});
				end
			end
			REQ_QUERY: begin
				awaited_answers.push_back('{RSP_MARK, 8'h00, 1'b0, row_ok && mark_flags[r]});
			end
			default: ;
		endcase
	endtask

	task automatic push_request(logic [2:0] op, logic [ROW_IDX_W-1:0] r,
			logic [COL_IDX_W-1:0] c, logic on, logic typed = 1'b0, logic typed_mark = 1'b0);
		int gap;
		gap = sender_idles ? $urandom_range(0, 4) : 0;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid    <= 1'b1;
		req_type     <= op;
		row_index    <= r;
		column_index <= c;
		is_on        <= on;
		do @(posedge clk); while (req_stall);
		if (typed) awaited_answers.push_back('{RSP_MARK, 8'h00, 1'b0, typed_mark});
		else apply_frame_request(op, int'(r), int'(c), on);
	endtask

	task automatic push_random_request();
		int                   pick;
		logic [2:0]           op;
		logic [ROW_IDX_W-1:0] r;
		logic [COL_IDX_W-1:0] c;
		pick = $urandom_range(0, 99);
		if (pick < 6) op = REQ_CLEAR;
		else if (pick < 36) op = REQ_SET_PIXEL;
		else if (pick < 52) op = REQ_ROW_SELECT;
		else if (pick < 62) op = REQ_UNMARK;
		else if (pick < 82) op = REQ_TRANSMIT;
		else if (pick < 94) op = REQ_QUERY;
		else if (pick < 97) op = REQ_SPARE_6;
		else op = REQ_SPARE_7;
		// mostly inside the matrix, now and then anywhere
		r = ($urandom_range(0, 9) != 0) ? ROW_IDX_W'($urandom_range(0, rows_in_use() - 1))
			: ROW_IDX_W'($urandom_range(0, 15));
		c = ($urandom_range(0, 9) != 0) ? COL_IDX_W'($urandom_range(0, cols_in_use() - 1))
			: COL_IDX_W'($urandom_range(0, 31));
		push_request(op, r, c, 1'($urandom_range(0, 1)));
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ROWS:      cfg_rows = value[4:0];
			REG_COLUMNS:   cfg_cols = value[5:0];
			REG_COL_LEVEL: cfg_col_level = value[0];
			REG_ROW_LEVEL: cfg_row_level = value[0];
			default: ;
		endcase
	endtask

	task automatic write_config(logic [4:0] rows, logic [5:0] cols, logic cl, logic rl);
		write_reg(REG_ROWS, {1'b0, rows});
		write_reg(REG_COLUMNS, cols);
		write_reg(REG_COL_LEVEL, {5'd0, cl});
		write_reg(REG_ROW_LEVEL, {5'd0, rl});
		cfg_valid <= 1'b0;
	endtask

	// a clear gives no answer, so allow it to finish after the queue empties
	task automatic wait_for_answers();
		req_valid <= 1'b0;
		while (awaited_answers.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic check_answer();
		answer_t seen;
		answer_t want;
		seen = '{result_kind, row_byte, last_byte, row_marked};
		if (awaited_answers.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected answer: kind %0b byte %02h last %0b mark %0b",
					seen.kind, seen.data, seen.last, seen.mark);
		end else begin
			want = awaited_answers.pop_front();
			if (seen.kind !== want.kind || seen.data !== want.data ||
					seen.last !== want.last || seen.mark !== want.mark) begin
				mismatches++;
				if (mismatches <= 10)
					$display("answer mismatch: expected kind %0b byte %02h last %0b mark %0b,",
						want.kind, want.data, want.last, want.mark,
						" got kind %0b byte %02h last %0b mark %0b",
						seen.kind, seen.data, seen.last, seen.mark);
			end
		end
	endtask

	// receiver side
	initial begin
		int hold;
		wait (arst_n === 1'b1);
		forever begin
			if (long_hold != 0) begin
				hold = long_hold;
				long_hold = 0;
			end else begin
				hold = receiver_idles ? $urandom_range(0, 4) : 0;
			end
			if (hold != 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
			check_answer();
		end
	end

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = REG_ROWS;
		cfg_data     = '0;
		req_valid    = 1'b0;
		req_type     = REQ_CLEAR;
		row_index    = '0;
		column_index = '0;
		is_on        = 1'b0;
		rsp_stall    = 1'b0;
		cfg_rows      = 5'd8;
		cfg_cols      = 6'd8;
		cfg_col_level = 1'b1;
		cfg_row_level = 1'b1;
		mark_flags    = '0;
		for (int s = 0; s < MAX_ROWS; s++) frame_bits[s] = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			push_request(directed[i].op, directed[i].row, directed[i].col, directed[i].on,
				directed[i].typed, directed[i].mark);

		for (int p = 0; p < 6; p++) begin
			wait_for_answers();
			write_config(phase_rows[p], phase_cols[p], phase_cl[p], phase_rl[p]);
			if (p == 4) begin
				sender_idles = 1'b0;
				receiver_idles = 1'b0;
			end
			push_request(REQ_CLEAR, ROW_IDX_W'($urandom_range(0, 15)),
				COL_IDX_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				push_random_request();
				if (p == 0 && n == 5) begin
					// back-pressure: receiver holds off while transmits pile up
					sender_idles = 1'b0;
					long_hold = HOLD_CYCLES;
					repeat (14)
						push_request(REQ_TRANSMIT, ROW_IDX_W'($urandom_range(0, 15)),
							COL_IDX_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
					sender_idles = 1'b1;
				end
				if (p == 2 && n == 8) wait_for_answers();
			end
			sender_idles = 1'b1;
			receiver_idles = 1'b1;
		end

		wait_for_answers();
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
